// ----- sv/assert_macros.svh -----
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- sv/ilha_pkg.sv -----
// package: types, constants and state codes of the heap allocator
package ilha_pkg;
  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_FREE    = 2'd1;
  localparam logic [1:0] ACT_REALLOC = 2'd2;
  localparam logic [31:0] A_BIT = 32'h1;
  localparam logic [31:0] P_BIT = 32'h2;
  localparam logic [31:0] SIZE_MASK = ~32'h3;
  localparam logic [31:0] HDR_BYTES = 32'd4;
  localparam logic [31:0] MIN_BLOCK = 32'd8;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] payload_offset;
    logic [16:0] request_size;
  } req_t;

  typedef struct packed {
    logic [15:0] result_offset;
    logic        moved;
    logic [15:0] copy_bytes;
  } rsp_t;

  // memory port request from the sequencer
  typedef struct packed {
    logic        rd_en;
    logic [31:0] rd_off;
    logic        wr_en;
    logic [31:0] wr_off;
    logic [31:0] wr_data;
  } mem_req_t;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE, S_DISPATCH,
    S_FIT_RD, S_FIT_WT,
    S_SPL_RD, S_SPL_WT, S_SPL_W2, S_SPL_NXRD, S_SPL_NXWT, S_SPL_NXWR, S_SPL_HDRRD, S_SPL_HDRWT,
    S_SPL_HDRWR, S_SPL_DONE,
    S_SET_A_RD, S_SET_A_WT,
    S_FR_RD, S_FR_WT, S_FR_NRD, S_FR_NWT, S_FR_PRD, S_FR_PWT, S_FR_PHRD, S_FR_PHWT,
    S_FR_SZRD, S_FR_SZWT, S_FR_FOOT, S_FR_NXRD, S_FR_NXWT,
    S_RA_RD, S_RA_WT, S_RA_NRD, S_RA_NWT, S_RA_GROW,
    S_RS_NRD, S_RS_NWT, S_RS_FOOT,
    S_RESP
  } state_t;
endpackage

// ----- sv/ilha_if.sv -----
// valid/ready channel interfaces for requests and responses
interface ilha_req_if;
  logic valid;
  logic ready;
  logic [1:0]  action;
  logic [15:0] payload_offset;
  logic [16:0] request_size;
  modport source(output valid, action, payload_offset, request_size, input ready);
  modport sink(input valid, action, payload_offset, request_size, output ready);
endinterface

interface ilha_rsp_if;
  logic valid;
  logic ready;
  logic [15:0] result_offset;
  logic        moved;
  logic [15:0] copy_bytes;
  modport source(output valid, result_offset, moved, copy_bytes, input ready);
  modport sink(input valid, result_offset, moved, copy_bytes, output ready);
endinterface

// ----- sv/ilha_ram.sv -----
// generic single-port-write, registered-read RAM
module ilha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ----- sv/ilha_store.sv -----
// tag store wrapper: byte-offset access, out-of-range reads give 0, writes dropped
module ilha_store #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic                clk,
  input  ilha_pkg::mem_req_t  req,
  output logic [31:0]         rdata
);
  import ilha_pkg::*;
  localparam int WORDS = HEAP_BYTES / 4;
  localparam int AW = $clog2(WORDS);
  logic [31:0] ridx, widx;
  logic        rin, rin_q;
  logic [31:0] ram_q;
  assign ridx = req.rd_off >> 2;
  assign widx = req.wr_off >> 2;
  assign rin  = ridx < 32'(WORDS);
  always_ff @(posedge clk) if (req.rd_en) rin_q <= rin;
  ilha_ram #(.WIDTH(32), .DEPTH(WORDS)) u_ram (
    .clk(clk),
    .we(req.wr_en && widx < 32'(WORDS)),
    .waddr(widx[AW-1:0]),
    .wdata(req.wr_data),
    .re(req.rd_en && rin),
    .raddr(ridx[AW-1:0]),
    .rdata(ram_q)
  );
  assign rdata = rin_q ? ram_q : 32'd0;
endmodule

// ----- sv/ilha_seq.sv -----
// sequencer: walks and rewrites block tags one memory access at a time
module ilha_seq #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  ilha_pkg::req_t     req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output ilha_pkg::rsp_t     rsp,
  output ilha_pkg::mem_req_t mem,
  input  logic [31:0]        rdata
);
  import ilha_pkg::*;
  localparam int WORDS = HEAP_BYTES / 4;
  localparam logic [31:0] EPI_OFF = 32'(HEAP_BYTES) - 32'd4;
  localparam logic [31:0] INIT_SZ = (32'(HEAP_BYTES) - 32'd4 + 32'd3) & SIZE_MASK;

  // return targets after shared subroutines
  typedef enum logic [2:0] {
    R_ALLOC, R_RA_MOVE, R_RA_SHRINK, R_RA_GROW, R_FREE_END
  } ret_t;

  // true when a byte offset maps to a word of the store
  function automatic logic in_heap(logic [31:0] off);
    return (off >> 2) < 32'(WORDS);
  endfunction

  state_t state, state_next;
  ret_t   ret, ret_next;
  req_t   r, r_next;
  logic [31:0] bp, bp_next, sz, sz_next, h, h_next, asz, asz_next;
  logic [31:0] cur, cur_next, cpy, cpy_next, cnt, cnt_next;
  logic [31:0] sz2, sz2_next;
  logic        split, split_next;
  rsp_t        out, out_next;
  logic [31:0] clr, clr_next;
  logic [31:0] size32, ptr32;
  logic        badp;
  logic        r_in;

  assign size32 = {15'd0, r.request_size};
  assign ptr32  = {16'd0, r.payload_offset};
  assign badp   = (ptr32[1:0] != 2'd0) || ptr32 < HDR_BYTES || (ptr32 - HDR_BYTES) >= EPI_OFF;
  // split remainder header lies inside the store
  assign r_in   = in_heap(bp + asz);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
    end
    ret <= ret_next; r <= r_next; bp <= bp_next; sz <= sz_next; h <= h_next;
    asz <= asz_next; cur <= cur_next; cpy <= cpy_next;
    cnt <= cnt_next; sz2 <= sz2_next; split <= split_next; out <= out_next;
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_RESP);
  assign rsp = out;

  always_comb begin
    state_next = state; ret_next = ret; r_next = r; bp_next = bp; sz_next = sz;
    h_next = h; asz_next = asz; cur_next = cur; cpy_next = cpy;
    cnt_next = cnt; sz2_next = sz2; split_next = split; out_next = out; clr_next = clr;
    mem = '0;
    case (state)
      S_CLEAR: begin
        // one word per cycle, initial tags placed as the sweep passes
        mem.wr_en = 1'b1;
        mem.wr_off = clr << 2;
        mem.wr_data = 32'd0;
        if ((clr << 2) == 32'd0) mem.wr_data = INIT_SZ | P_BIT;
        else if ((clr << 2) == INIT_SZ - 32'd4) mem.wr_data = INIT_SZ;
        else if ((clr << 2) == EPI_OFF) mem.wr_data = A_BIT;
        clr_next = clr + 32'd1;
        if (clr == 32'(WORDS - 1)) state_next = S_IDLE;
      end
      S_IDLE: if (req_valid) begin
        r_next = req; state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        out_next = '0;
        if (r.action == ACT_ALLOC || (r.action == ACT_REALLOC && ptr32 == 32'd0)) begin
          ret_next = R_ALLOC;
          if (size32 == 32'd0) state_next = S_RESP;
          else begin
            asz_next = (size32 + HDR_BYTES + 32'd3) & SIZE_MASK;
            bp_next = '0; cnt_next = '0; state_next = S_FIT_RD;
          end
        end else if (r.action == ACT_FREE || (r.action == ACT_REALLOC && size32 == 32'd0
                                               && !badp)) begin
          ret_next = R_FREE_END;
          if (ptr32 == 32'd0 || badp) state_next = S_RESP;
          else begin bp_next = ptr32 - HDR_BYTES; state_next = S_FR_RD; end
        end else if (r.action == ACT_REALLOC && !badp) begin
          bp_next = ptr32 - HDR_BYTES;
          asz_next = (size32 + HDR_BYTES + 32'd3) & SIZE_MASK;
          state_next = S_RA_RD;
        end else state_next = S_RESP;
      end
      // ---- first-fit walk ----
      S_FIT_RD: begin
        if (cnt > 32'(WORDS) || bp >= EPI_OFF) begin
          state_next = (ret == R_RA_MOVE) ? S_RESP : S_RESP;
        end else begin
          mem.rd_en = 1'b1; mem.rd_off = bp; state_next = S_FIT_WT;
        end
      end
      S_FIT_WT: begin
        if (!rdata[0] && (rdata & SIZE_MASK) >= asz) begin
          split_next = 1'b0; state_next = S_SPL_RD;
        end else if ((rdata & SIZE_MASK) == 32'd0) state_next = S_RESP;
        else begin
          bp_next = bp + (rdata & SIZE_MASK); cnt_next = cnt + 32'd1; state_next = S_FIT_RD;
        end
      end
      // ---- split_block(bp, asz) ----
      S_SPL_RD: begin mem.rd_en = 1'b1; mem.rd_off = bp; state_next = S_SPL_WT; end
      S_SPL_WT: begin
        h_next = rdata; sz_next = rdata & SIZE_MASK;
        if ((rdata & SIZE_MASK) - asz >= MIN_BLOCK) begin
          mem.wr_en = 1'b1; mem.wr_off = bp + asz;
          mem.wr_data = (((rdata & SIZE_MASK) - asz) & SIZE_MASK) | P_BIT;
          split_next = 1'b1; state_next = S_SPL_W2;
        end else begin
          split_next = 1'b0; state_next = S_SPL_NXRD;
        end
      end
      S_SPL_W2: begin
        // footer of remainder, size reads back as 0 past the store
        mem.wr_en = 1'b1;
        mem.wr_off = bp + asz + (r_in ? ((sz - asz) & SIZE_MASK) : 32'd0) - 32'd4;
        mem.wr_data = r_in ? ((sz - asz) & SIZE_MASK) : 32'd0;
        state_next = S_SPL_NXRD;
      end
      S_SPL_NXRD: begin mem.rd_en = 1'b1; mem.rd_off = bp + sz; state_next = S_SPL_NXWT; end
      S_SPL_NXWT: begin
        mem.wr_en = 1'b1; mem.wr_off = bp + sz;
        mem.wr_data = split ? (rdata & ~P_BIT) : (rdata | P_BIT);
        state_next = split ? S_SPL_HDRRD : S_SPL_DONE;
      end
      S_SPL_HDRRD: begin mem.rd_en = 1'b1; mem.rd_off = bp; state_next = S_SPL_HDRWT; end
      S_SPL_HDRWT: begin
        mem.wr_en = 1'b1; mem.wr_off = bp;
        mem.wr_data = (asz & SIZE_MASK) | (rdata & (A_BIT | P_BIT));
        state_next = S_SPL_DONE;
      end
      S_SPL_DONE: begin
        case (ret)
          R_ALLOC, R_RA_MOVE: state_next = S_SET_A_RD;
          R_RA_SHRINK: begin
            if (split) state_next = S_RS_NRD;
            else begin out_next.result_offset = r.payload_offset; state_next = S_RESP; end
          end
          R_RA_GROW: begin out_next.result_offset = r.payload_offset; state_next = S_RESP; end
          default: state_next = S_RESP;
        endcase
      end
      S_SET_A_RD: begin mem.rd_en = 1'b1; mem.rd_off = bp; state_next = S_SET_A_WT; end
      S_SET_A_WT: begin
        mem.wr_en = 1'b1; mem.wr_off = bp; mem.wr_data = rdata | A_BIT;
        if (ret == R_RA_MOVE) begin
          bp_next = ptr32 - HDR_BYTES; ret_next = R_FREE_END;
          out_next.moved = 1'b1; out_next.copy_bytes = cpy[15:0];
          out_next.result_offset = 16'(bp + HDR_BYTES);
          state_next = S_FR_RD;
        end else begin
          out_next.result_offset = 16'(bp + HDR_BYTES); state_next = S_RESP;
        end
      end
      // ---- do_free(bp) ----
      S_FR_RD: begin mem.rd_en = 1'b1; mem.rd_off = bp; state_next = S_FR_WT; end
      S_FR_WT: begin
        h_next = rdata & ~A_BIT; sz_next = rdata & SIZE_MASK;
        mem.wr_en = 1'b1; mem.wr_off = bp; mem.wr_data = rdata & ~A_BIT;
        state_next = S_FR_NRD;
      end
      S_FR_NRD: begin mem.rd_en = 1'b1; mem.rd_off = bp + sz; state_next = S_FR_NWT; end
      S_FR_NWT: begin
        if (!rdata[0]) sz_next = sz + (rdata & SIZE_MASK);
        state_next = h[1] ? S_FR_SZRD : S_FR_PRD;
      end
      S_FR_PRD: begin mem.rd_en = 1'b1; mem.rd_off = bp - 32'd4; state_next = S_FR_PWT; end
      S_FR_PWT: begin bp_next = bp - rdata; state_next = S_FR_PHRD; end
      S_FR_PHRD: begin mem.rd_en = 1'b1; mem.rd_off = bp; state_next = S_FR_PHWT; end
      S_FR_PHWT: begin sz_next = sz + (rdata & SIZE_MASK); state_next = S_FR_SZRD; end
      S_FR_SZRD: begin mem.rd_en = 1'b1; mem.rd_off = bp; state_next = S_FR_SZWT; end
      S_FR_SZWT: begin
        mem.wr_en = 1'b1; mem.wr_off = bp;
        mem.wr_data = (sz & SIZE_MASK) | (rdata & (A_BIT | P_BIT));
        // a header past the store reads back as size 0
        sz_next = in_heap(bp) ? (sz & SIZE_MASK) : 32'd0;
        state_next = S_FR_FOOT;
      end
      S_FR_FOOT: begin
        mem.wr_en = 1'b1; mem.wr_off = bp + sz - 32'd4; mem.wr_data = sz;
        state_next = S_FR_NXRD;
      end
      S_FR_NXRD: begin mem.rd_en = 1'b1; mem.rd_off = bp + sz; state_next = S_FR_NXWT; end
      S_FR_NXWT: begin
        mem.wr_en = 1'b1; mem.wr_off = bp + sz; mem.wr_data = rdata & ~P_BIT;
        state_next = S_RESP;
      end
      // ---- reallocate ----
      S_RA_RD: begin mem.rd_en = 1'b1; mem.rd_off = bp; state_next = S_RA_WT; end
      S_RA_WT: begin
        cur_next = rdata & SIZE_MASK; h_next = rdata;
        if ((rdata & SIZE_MASK) >= asz) begin
          ret_next = R_RA_SHRINK; state_next = S_SPL_RD;
        end else state_next = S_RA_NRD;
      end
      S_RA_NRD: begin mem.rd_en = 1'b1; mem.rd_off = bp + cur; state_next = S_RA_NWT; end
      S_RA_NWT: begin
        if (!rdata[0] && cur + (rdata & SIZE_MASK) >= asz) begin
          mem.wr_en = 1'b1; mem.wr_off = bp;
          mem.wr_data = ((cur + (rdata & SIZE_MASK)) & SIZE_MASK) | (h & (A_BIT | P_BIT));
          ret_next = R_RA_GROW; state_next = S_RA_GROW;
        end else begin
          cpy_next = (size32 < cur - HDR_BYTES) ? size32 : cur - HDR_BYTES;
          ret_next = R_RA_MOVE; bp_next = '0; cnt_next = '0; state_next = S_FIT_RD;
        end
      end
      S_RA_GROW: state_next = S_SPL_RD;
      // shrink remainder merge
      S_RS_NRD: begin
        sz2_next = r_in ? ((sz - asz) & SIZE_MASK) : 32'd0;
        mem.rd_en = 1'b1;
        mem.rd_off = bp + asz + (r_in ? ((sz - asz) & SIZE_MASK) : 32'd0);
        state_next = S_RS_NWT;
      end
      S_RS_NWT: begin
        out_next.result_offset = r.payload_offset;
        if (!rdata[0] && (rdata & SIZE_MASK) != 32'd0) begin
          sz2_next = sz2 + (rdata & SIZE_MASK);
          mem.wr_en = 1'b1; mem.wr_off = bp + asz;
          mem.wr_data = ((sz2 + (rdata & SIZE_MASK)) & SIZE_MASK) | P_BIT;
          state_next = S_RS_FOOT;
        end else state_next = S_RESP;
      end
      S_RS_FOOT: begin
        mem.wr_en = 1'b1;
        mem.wr_off = bp + asz + (r_in ? (sz2 & SIZE_MASK) : 32'd0) - 32'd4;
        mem.wr_data = r_in ? (sz2 & SIZE_MASK) : 32'd0;
        state_next = S_RESP;
      end
      S_RESP: if (rsp_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ----- sv/implicit_list_heap_allocator.sv -----
// top level: first-fit implicit free-list allocator over a tag memory
// a null free or a refused item goes from accept through dispatch to the result; a
// reallocate that moves its block walks the tags, splits, marks and then frees the old one
// one item at a time; the next item can be accepted in the cycle after the result is taken
// reset: synchronous rst starts a clearing sweep over every word of the store that also writes
// the initial free block, its footer and the epilogue; no item is taken during the sweep
module implicit_list_heap_allocator #(
  parameter int HEAP_BYTES = 65536
) (
  input logic clk,
  input logic rst,
  ilha_req_if.sink   req,
  ilha_rsp_if.source rsp
);
  import ilha_pkg::*;
  // request and response payloads as structs
  req_t     rq;
  rsp_t     rs;
  mem_req_t mq;
  logic [31:0] rdata;

  assign rq.action = req.action;
  assign rq.payload_offset = req.payload_offset;
  assign rq.request_size = req.request_size;
  assign rsp.result_offset = rs.result_offset;
  assign rsp.moved = rs.moved;
  assign rsp.copy_bytes = rs.copy_bytes;

  // sequencer holds one item from accept to response
  ilha_seq #(.HEAP_BYTES(HEAP_BYTES)) u_seq (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_ready(req.ready), .req(rq),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(rs),
    .mem(mq), .rdata(rdata)
  );

  // tag memory, one word per 4 heap bytes
  ilha_store #(.HEAP_BYTES(HEAP_BYTES)) u_store (
    .clk(clk), .req(mq), .rdata(rdata)
  );
endmodule

// ----- sv/ilha_checker.sv -----
// port-level checker for the allocator, bound to the top level
`include "assert_macros.svh"
module ilha_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] result_offset,
  input logic        moved,
  input logic [15:0] copy_bytes
);
  `ASSERT_IMPL(a_no_overlap, clk, rst, out_valid, !in_ready, "input taken while result pending")
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(result_offset), "result dropped")
  `ASSERT_IMPL(a_copy_moved, clk, rst, out_valid && !moved, copy_bytes == 16'd0, "copy without move")
  `ASSERT_IMPL(a_align, clk, rst, out_valid, result_offset[1:0] == 2'd0, "misaligned result")
endmodule

bind implicit_list_heap_allocator ilha_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready),
  .result_offset(rsp.result_offset), .moved(rsp.moved), .copy_bytes(rsp.copy_bytes)
);
